[design/thdrk_pkg.sv]
// package: types, constants and map entry helpers for the dual-role key remapper
`timescale 1ns / 1ps
package thdrk_pkg;

    // sizes
    localparam int MAP_ENTRIES  = 4;
    localparam int ENT_W        = $clog2(MAP_ENTRIES);
    localparam int CODE_W       = 10;
    localparam int DELAY_W      = 16;
    localparam int MAP_W        = 30;
    localparam int CFG_W        = MAP_W;
    localparam int CFG_IDX_W    = 3;
    localparam int MAX_RES      = 5;
    localparam int RES_CNT_W    = $clog2(MAX_RES + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAP_FIRST  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MAP_LAST   = CFG_IDX_W'(MAP_ENTRIES);

    // reset value of the hold delay
    localparam logic [DELAY_W-1:0] HOLD_DELAY_RST = DELAY_W'(300);

    // input codes
    localparam logic       CMD_KEY     = 1'b0;
    localparam logic       CMD_TICK    = 1'b1;
    localparam logic [1:0] ACT_RELEASE = 2'd0;
    localparam logic [1:0] ACT_PRESS   = 2'd1;

    // input beat
    typedef struct packed {
        logic              command;
        logic [CODE_W-1:0] key_code;
        logic [1:0]        key_action;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [CODE_W-1:0] out_code;
        logic              out_pressed;
        logic              last_of_run;
    } t_out_beat;

    typedef logic [MAP_W-1:0]       t_map_entry;
    typedef logic [MAP_ENTRIES-1:0] t_entry_mask;

    // physical key of an entry, zero means empty
    function automatic logic [CODE_W-1:0] ent_key(input t_map_entry ent);
        return ent[9:0];
    endfunction

    // secondary code, zero means not dual-role
    function automatic logic [CODE_W-1:0] ent_sec(input t_map_entry ent);
        return ent[29:20];
    endfunction

    // primary code, falls back to the key itself
    function automatic logic [CODE_W-1:0] ent_pri(input t_map_entry ent);
        return (ent[19:10] != '0) ? ent[19:10] : ent[9:0];
    endfunction

endpackage

[design/tap_hold_dual_role_keys.sv]
// top level: dual-role key remapper with tick-driven hold timeout
// flow: an accepted beat is registered, handled once the result buffer is empty, and
//   its results go through the result buffer and the output register to o_valid
// throughput: with the result buffer empty, one beat per cycle for beats with no result;
//   after a beat with results (at most 5) the next one waits until the buffer drains
// reset (i_rst_n low, synchronous): key state and buffers cleared, hold delay 300,
//   all map entries empty
`timescale 1ns / 1ps
module tap_hold_dual_role_keys
    import thdrk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    input  t_in_beat             i_data,
    output logic                 o_stall,
    // output channel
    output logic                 o_valid,
    output t_out_beat            o_data,
    input  logic                 i_stall,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // configuration registers
    logic [DELAY_W-1:0] r_hold_delay;
    t_map_entry         r_map [MAP_ENTRIES];

    // per-entry key state
    t_entry_mask        r_held, n_held;
    t_entry_mask        r_pend, n_pend;
    t_entry_mask        r_secdn, n_secdn;
    logic [DELAY_W-1:0] r_cd [MAP_ENTRIES];
    logic [DELAY_W-1:0] n_cd [MAP_ENTRIES];

    // input register
    logic               r_in_valid;
    t_in_beat           r_in;

    // result buffer, slot 0 is the head
    t_out_beat          r_slot [MAX_RES];
    t_out_beat          n_slot [MAX_RES];
    logic [RES_CNT_W-1:0] r_buf_cnt, n_cnt;

    // output register
    logic               r_out_valid;
    t_out_beat          r_out;

    logic               proc;
    logic               pop;
    logic               found;
    logic               dual;
    logic [ENT_W-1:0]   e_idx;
    logic [CODE_W-1:0]  pri_code;
    logic               cfg_map_wr;
    logic [ENT_W-1:0]   cfg_ent;
    logic [CFG_IDX_W-1:0] cfg_off;

    assign proc    = r_in_valid && (r_buf_cnt == '0);
    assign pop     = (r_buf_cnt != '0) && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && (r_buf_cnt != '0);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign cfg_map_wr = i_cfg_we && (i_cfg_idx >= REG_MAP_FIRST) && (i_cfg_idx <= REG_MAP_LAST);
    assign cfg_off    = i_cfg_idx - REG_MAP_FIRST;
    assign cfg_ent    = cfg_off[ENT_W-1:0];

    // entry lookup: first nonempty entry with this key
    always_comb begin
        found = 1'b0;
        e_idx = '0;
        for (int i = 0; i < MAP_ENTRIES; i++) begin
            if (!found && ent_key(r_map[i]) != '0 && ent_key(r_map[i]) == r_in.key_code) begin
                found = 1'b1;
                e_idx = ENT_W'(i);
            end
        end
        dual     = found && (ent_sec(r_map[e_idx]) != '0);
        pri_code = found ? ent_pri(r_map[e_idx]) : r_in.key_code;
    end

    // one pass over the registered beat: next key state and the result list
    always_comb begin
        logic was_pend;
        n_held   = r_held;
        n_pend   = r_pend;
        n_secdn  = r_secdn;
        n_cd     = r_cd;
        n_cnt    = '0;
        was_pend = 1'b0;
        for (int k = 0; k < MAX_RES; k++) begin
            n_slot[k] = '0;
        end

        if (proc) begin
            if (r_in.command == CMD_TICK) begin
                // countdown of every pending entry
                for (int i = 0; i < MAP_ENTRIES; i++) begin
                    if (n_pend[i]) begin
                        if (n_cd[i] != '0) begin
                            n_cd[i] = n_cd[i] - DELAY_W'(1);
                        end
                        if (n_cd[i] == '0) begin
                            n_pend[i] = 1'b0;
                            if (!n_secdn[i]) begin
                                if (n_cnt < RES_CNT_W'(MAX_RES)) begin
                                    n_slot[n_cnt] = '{ent_sec(r_map[i]), 1'b1, 1'b0};
                                    n_cnt = n_cnt + RES_CNT_W'(1);
                                end
                                n_secdn[i] = 1'b1;
                            end
                        end
                    end
                end
            end else if (dual) begin
                priority if (r_in.key_action == ACT_RELEASE) begin
                    was_pend       = n_pend[e_idx];
                    n_held[e_idx]  = 1'b0;
                    n_pend[e_idx]  = 1'b0;
                    if (n_secdn[e_idx]) begin
                        if (n_cnt < RES_CNT_W'(MAX_RES)) begin
                            n_slot[n_cnt] = '{ent_sec(r_map[e_idx]), 1'b0, 1'b0};
                            n_cnt = n_cnt + RES_CNT_W'(1);
                        end
                        n_secdn[e_idx] = 1'b0;
                    end else if (was_pend) begin
                        // tap: other held keys go secondary, then primary down and up
                        for (int i = 0; i < MAP_ENTRIES; i++) begin
                            if (n_held[i]) begin
                                n_pend[i] = 1'b0;
                                if (!n_secdn[i]) begin
                                    if (n_cnt < RES_CNT_W'(MAX_RES)) begin
                                        n_slot[n_cnt] = '{ent_sec(r_map[i]), 1'b1, 1'b0};
                                        n_cnt = n_cnt + RES_CNT_W'(1);
                                    end
                                    n_secdn[i] = 1'b1;
                                end
                            end
                        end
                        if (n_cnt < RES_CNT_W'(MAX_RES)) begin
                            n_slot[n_cnt] = '{pri_code, 1'b1, 1'b0};
                            n_cnt = n_cnt + RES_CNT_W'(1);
                        end
                        if (n_cnt < RES_CNT_W'(MAX_RES)) begin
                            n_slot[n_cnt] = '{pri_code, 1'b0, 1'b0};
                            n_cnt = n_cnt + RES_CNT_W'(1);
                        end
                    end
                end else if (r_in.key_action == ACT_PRESS) begin
                    n_held[e_idx] = 1'b1;
                    n_pend[e_idx] = 1'b1;
                    n_cd[e_idx]   = r_hold_delay;
                end else begin
                    // autorepeat and unused code: nothing
                end
            end else begin
                priority if (r_in.key_action == ACT_RELEASE) begin
                    n_slot[0] = '{pri_code, 1'b0, 1'b0};
                    n_cnt     = RES_CNT_W'(1);
                end else if (r_in.key_action == ACT_PRESS) begin
                    // another key decides every held dual-role key
                    for (int i = 0; i < MAP_ENTRIES; i++) begin
                        if (n_held[i]) begin
                            n_pend[i] = 1'b0;
                            if (!n_secdn[i]) begin
                                if (n_cnt < RES_CNT_W'(MAX_RES)) begin
                                    n_slot[n_cnt] = '{ent_sec(r_map[i]), 1'b1, 1'b0};
                                    n_cnt = n_cnt + RES_CNT_W'(1);
                                end
                                n_secdn[i] = 1'b1;
                            end
                        end
                    end
                    if (n_cnt < RES_CNT_W'(MAX_RES)) begin
                        n_slot[n_cnt] = '{pri_code, 1'b1, 1'b0};
                        n_cnt = n_cnt + RES_CNT_W'(1);
                    end
                end else begin
                    // autorepeat and unused code: nothing
                end
            end

            // mark the final result of the run
            if (n_cnt != '0) begin
                n_slot[n_cnt - RES_CNT_W'(1)].last_of_run = 1'b1;
            end
        end

        // map entry rewrite clears that entry's state
        if (cfg_map_wr) begin
            n_held[cfg_ent]  = 1'b0;
            n_pend[cfg_ent]  = 1'b0;
            n_secdn[cfg_ent] = 1'b0;
            n_cd[cfg_ent]    = '0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_delay <= HOLD_DELAY_RST;
            for (int i = 0; i < MAP_ENTRIES; i++) begin
                r_map[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_HOLD_DELAY) begin
                r_hold_delay <= i_cfg_data[DELAY_W-1:0];
            end
            if (cfg_map_wr) begin
                r_map[cfg_ent] <= i_cfg_data[MAP_W-1:0];
            end
        end
    end

    // key state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_pend  <= '0;
            r_secdn <= '0;
            for (int i = 0; i < MAP_ENTRIES; i++) begin
                r_cd[i] <= '0;
            end
        end else begin
            r_held  <= n_held;
            r_pend  <= n_pend;
            r_secdn <= n_secdn;
            r_cd    <= n_cd;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
    end

    // result buffer: load a whole run, shift out one beat at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_cnt <= '0;
        end else if (proc) begin
            r_buf_cnt <= n_cnt;
        end else if (pop) begin
            r_buf_cnt <= r_buf_cnt - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_slot <= n_slot;
        end else if (pop) begin
            for (int k = 0; k < MAX_RES - 1; k++) begin
                r_slot[k] <= r_slot[k + 1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= r_slot[0];
        end
    end

`ifndef SYNTH
    // a pending decision always belongs to a held key
    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & ~r_held) == '0)
        else $error("pending decision on a key that is not held");

    // the buffer never holds more than one run
    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf_cnt <= RES_CNT_W'(MAX_RES))
        else $error("result buffer count out of range");

    // a beat waiting on an empty buffer is handled at once
    a_proc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && !(i_valid && !o_stall)) |=> !r_in_valid)
        else $error("registered beat not consumed");

    // the last beat shifted out of a run carries the end mark
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_buf_cnt == RES_CNT_W'(1)) |-> r_slot[0].last_of_run)
        else $error("run ends without last_of_run");
`endif

endmodule
